/* src/ln_taylor_series_unit_defines.svh */
// ----------------------------------------------------------------------------
// ln_taylor_series_unit_defines.svh
// Assertion macros shared by the natural log series unit.
// ----------------------------------------------------------------------------
`ifndef LN_TAYLOR_SERIES_UNIT_DEFINES_SVH
`define LN_TAYLOR_SERIES_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LNTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LNTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lnts_pkg.sv */
// ----------------------------------------------------------------------------
// lnts_pkg
// Types, microcode codes and fixed-point constants for the log series unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lnts_pkg;

  // Fixed-point format of the argument and the result.
  localparam int FRAC_BITS = 28;
  localparam int PROD_SH_W = 64 - FRAC_BITS;

  localparam logic [27:0] TOL_RESET = 28'd268;
  localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRAC_BITS;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [PROD_SH_W-1:0] POS_LIM = PROD_SH_W'(32'h7FFF_FFFF);
  localparam logic [PROD_SH_W-1:0] NEG_LIM = PROD_SH_W'(32'h8000_0000);

  typedef logic [3:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [3:0] step_t;

  // Datapath operations.
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_ACCEPT   = 4'd1;
  localparam op_t OP_ADD      = 4'd2;
  localparam op_t OP_POWER    = 4'd3;
  localparam op_t OP_DIV_INIT = 4'd4;
  localparam op_t OP_DIV_STEP = 4'd5;
  localparam op_t OP_LIMIT    = 4'd6;
  localparam op_t OP_FINISH   = 4'd7;

  // Jump conditions.
  localparam cond_t C_NEXT       = 3'd0;
  localparam cond_t C_ALWAYS     = 3'd1;
  localparam cond_t C_NO_INPUT   = 3'd2;
  localparam cond_t C_TERM_SMALL = 3'd3;
  localparam cond_t C_AT_CAP     = 3'd4;
  localparam cond_t C_DIV_MORE   = 3'd5;
  localparam cond_t C_OUT_BUSY   = 3'd6;

  // Program addresses.
  localparam step_t ST_ACCEPT   = 4'd0;
  localparam step_t ST_TEST_TOL = 4'd1;
  localparam step_t ST_TEST_CAP = 4'd2;
  localparam step_t ST_ADD      = 4'd3;
  localparam step_t ST_POWER    = 4'd4;
  localparam step_t ST_DIV_INIT = 4'd5;
  localparam step_t ST_DIV_STEP = 4'd6;
  localparam step_t ST_LOOP     = 4'd7;
  localparam step_t ST_LIMIT    = 4'd8;
  localparam step_t ST_FINISH   = 4'd9;
  localparam step_t ST_RETURN   = 4'd10;

  // One control word of the microprogram.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Condition flags from the datapath to the sequencer.
  typedef struct packed {
    logic term_small;
    logic at_cap;
    logic div_more;
    logic out_busy;
  } stat_t;

  // Magnitude of a 32-bit two's complement value; the most negative value
  // maps to 2^31.
  function automatic logic [31:0] magn32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

/* src/ln_taylor_series_unit.sv */
// ----------------------------------------------------------------------------
// ln_taylor_series_unit
// Natural logarithm by the Mercator series, run by a microprogram.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_x_value (Q3.28)
//   out      output     out_valid/out_ready  out_ln_value, out_terms_used,
//                                            out_limit_reached, out_saturated
//   cfg      input      cfg_valid/cfg_ready  cfg_tolerance (Q0.28)
//
// Each term runs the tolerance and cap tests, add, power update, divider
// setup and the one-bit-per-cycle divider that forms power / n; the term
// cap ends the loop through an extra limit step. in_ready is high only at
// the accept step. A waiting result does not block the next accept; the
// finish step stalls until the previous result beat is taken.
// Synchronous active-low reset sets the tolerance to 268 and clears valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ln_taylor_series_unit_defines.svh"

module ln_taylor_series_unit #(
  parameter int MAX_TERMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_ln_value,
  output logic [6:0]         out_terms_used,
  output logic               out_limit_reached,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [27:0]        cfg_tolerance
);
  import lnts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  lnts_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // Datapath.
  lnts_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_valid          (in_valid),
    .in_x_value        (in_x_value),
    .cfg_valid         (cfg_valid),
    .cfg_tolerance     (cfg_tolerance),
    .out_ready         (out_ready),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ln_value      (out_ln_value),
    .out_terms_used    (out_terms_used),
    .out_limit_reached (out_limit_reached),
    .out_saturated     (out_saturated)
  );

  // A term is never added once the count has reached the cap.
  `LNTS_ASSERT_NOW(a_no_add_at_cap, ctrl.op == OP_ADD, !stat.at_cap, "term added at cap")

  // The cap flag only comes with a full count of terms.
  `LNTS_ASSERT_NOW(a_limit_count, out_valid && out_limit_reached,
    out_terms_used == 7'(MAX_TERMS), "limit flag without full term count")

  // After an accepted beat the sequencer leaves the accept step.
  `LNTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input ready right after an accepted beat")

endmodule

/* src/lnts_seq.sv */
// ----------------------------------------------------------------------------
// lnts_seq
// Microprogram sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnts_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  lnts_pkg::stat_t stat,
  output lnts_pkg::ctrl_t ctrl,
  output logic            in_ready
);
  import lnts_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  ctrl_t word;
  logic  take;

  // Control store: one word per program step.
  function automatic ctrl_t rom_word(input step_t a);
    ctrl_t w;
    case (a)
      ST_ACCEPT:   w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,   target: ST_ACCEPT};
      ST_TEST_TOL: w = '{op: OP_NOP,      cond: C_TERM_SMALL, target: ST_FINISH};
      ST_TEST_CAP: w = '{op: OP_NOP,      cond: C_AT_CAP,     target: ST_LIMIT};
      ST_ADD:      w = '{op: OP_ADD,      cond: C_NEXT,       target: ST_ACCEPT};
      ST_POWER:    w = '{op: OP_POWER,    cond: C_NEXT,       target: ST_ACCEPT};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,       target: ST_ACCEPT};
      ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: ST_DIV_STEP};
      ST_LOOP:     w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_TEST_TOL};
      ST_LIMIT:    w = '{op: OP_LIMIT,    cond: C_NEXT,       target: ST_ACCEPT};
      ST_FINISH:   w = '{op: OP_FINISH,   cond: C_OUT_BUSY,   target: ST_FINISH};
      ST_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_ACCEPT};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_ACCEPT};
    endcase
    return w;
  endfunction

  assign word     = rom_word(pc_r);
  assign ctrl     = word;
  assign in_ready = (word.op == OP_ACCEPT);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (word.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_INPUT:   take = !in_valid;
      C_TERM_SMALL: take = stat.term_small;
      C_AT_CAP:     take = stat.at_cap;
      C_DIV_MORE:   take = stat.div_more;
      C_OUT_BUSY:   take = stat.out_busy;
      default:      take = 1'b0;
    endcase
    pc_nxt = take ? word.target : pc_r + step_t'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* src/lnts_dp.sv */
// ----------------------------------------------------------------------------
// lnts_dp
// Series datapath: argument setup, power multiply, serial divide by the term
// index, wide accumulator and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lnts_dp #(
  parameter int MAX_TERMS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lnts_pkg::ctrl_t    ctrl,
  input  logic               in_valid,
  input  logic signed [31:0] in_x_value,
  input  logic               cfg_valid,
  input  logic [27:0]        cfg_tolerance,
  input  logic               out_ready,
  output lnts_pkg::stat_t    stat,
  output logic               out_valid,
  output logic signed [31:0] out_ln_value,
  output logic [6:0]         out_terms_used,
  output logic               out_limit_reached,
  output logic               out_saturated
);
  import lnts_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int NW = $clog2(MAX_TERMS + 2);
  localparam int SW = 32 + CW + 1;

  logic [27:0]          tol_r;
  logic                 out_valid_r;
  logic [31:0]          u_r;
  logic [31:0]          power_r;
  logic [31:0]          term_mag_r;
  logic                 term_neg_r;
  logic signed [SW-1:0] sum_r;
  logic [CW-1:0]        count_r;
  logic [63:0]          prod_r;
  logic [31:0]          quo_r;
  logic [NW-1:0]        rem_r;
  logic [4:0]           div_cnt_r;
  logic                 sat_r;
  logic                 limit_r;
  logic [31:0]          ln_r;
  logic [6:0]           terms_r;
  logic                 lim_out_r;
  logic                 sat_out_r;

  logic                 accept;
  logic                 finish;
  logic [32:0]          u_wide;
  logic                 u_ovf;
  logic [31:0]          u_clip;
  logic [PROD_SH_W-1:0] p_mag;
  logic                 p_neg;
  logic [31:0]          power_nxt;
  logic                 power_clip;
  logic [NW-1:0]        divisor;
  logic [NW:0]          shifted;
  logic                 ge;
  logic [NW-1:0]        rem_nxt;
  logic [31:0]          quo_nxt;
  logic signed [SW-1:0] term_ext;
  logic                 sum_fits;
  logic [31:0]          ln_nxt;

  assign accept = (ctrl.op == OP_ACCEPT) && in_valid;
  assign finish = (ctrl.op == OP_FINISH) && !stat.out_busy;

  // Condition flags for the sequencer.
  assign stat.term_small = (term_mag_r <= {4'b0, tol_r});
  assign stat.at_cap     = (count_r >= CW'(MAX_TERMS));
  assign stat.div_more   = (div_cnt_r != 5'd31);
  assign stat.out_busy   = out_valid_r && !out_ready;

  // u = x - 1, clipped to 32 bits; only the low side can overflow.
  assign u_wide = {in_x_value[31], in_x_value} - ONE_Q;
  assign u_ovf  = u_wide[32] != u_wide[31];
  assign u_clip = u_ovf ? S32_MIN : u_wide[31:0];

  // Next power is -(power * u), rounded toward zero and clipped.
  assign p_mag = prod_r[63:FRAC_BITS];
  assign p_neg = (power_r[31] == u_r[31]);
  always_comb begin
    power_clip = 1'b0;
    if (p_neg) begin
      if (p_mag > NEG_LIM) begin
        power_nxt  = S32_MIN;
        power_clip = 1'b1;
      end else begin
        power_nxt = ~p_mag[31:0] + 32'd1;
      end
    end else begin
      if (p_mag > POS_LIM) begin
        power_nxt  = S32_MAX;
        power_clip = 1'b1;
      end else begin
        power_nxt = p_mag[31:0];
      end
    end
  end

  // One restoring division step by the term index n = count + 1.
  assign divisor = NW'(count_r) + NW'(1);
  assign shifted = {rem_r, quo_r[31]};
  assign ge      = shifted >= {1'b0, divisor};
  assign rem_nxt = ge ? NW'(shifted - {1'b0, divisor}) : shifted[NW-1:0];
  assign quo_nxt = {quo_r[30:0], ge};

  // Signed term for the accumulator.
  assign term_ext = term_neg_r ? -SW'({1'b0, term_mag_r}) : SW'({1'b0, term_mag_r});

  // Final clip of the sum to 32 bits.
  assign sum_fits = (sum_r[SW-1:31] == '0) || (sum_r[SW-1:31] == '1);
  assign ln_nxt   = sum_fits ? sum_r[31:0] : (sum_r[SW-1] ? S32_MIN : S32_MAX);

  // Control registers: tolerance and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol_r <= cfg_tolerance;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, driven by the current control word.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (accept) begin
          u_r        <= u_clip;
          power_r    <= u_clip;
          term_mag_r <= magn32(u_clip);
          term_neg_r <= u_clip[31];
          sum_r      <= '0;
          count_r    <= '0;
          sat_r      <= u_ovf;
          limit_r    <= 1'b0;
        end
      end
      OP_ADD: begin
        sum_r   <= sum_r + term_ext;
        count_r <= count_r + CW'(1);
        prod_r  <= magn32(power_r) * magn32(u_r);
      end
      OP_POWER: begin
        power_r <= power_nxt;
        sat_r   <= sat_r | power_clip;
      end
      OP_DIV_INIT: begin
        quo_r      <= magn32(power_r);
        rem_r      <= '0;
        div_cnt_r  <= '0;
        term_neg_r <= power_r[31];
      end
      OP_DIV_STEP: begin
        quo_r     <= quo_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (!stat.div_more) begin
          term_mag_r <= quo_nxt;
        end
      end
      OP_LIMIT: begin
        limit_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (finish) begin
      ln_r      <= ln_nxt;
      terms_r   <= 7'(count_r);
      lim_out_r <= limit_r;
      sat_out_r <= sat_r | !sum_fits;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ln_value      = ln_r;
  assign out_terms_used    = terms_r;
  assign out_limit_reached = lim_out_r;
  assign out_saturated     = sat_out_r;

endmodule

/* tb/ln_taylor_series_unit_test.sv */
// ----------------------------------------------------------------------------
// ln_taylor_series_unit_test
// Self-checking bench for the natural log series unit. Each accepted argument
// beat is run through a local Mercator series predictor, and every result
// beat is compared field by field with the oldest prediction. It covers
// directed edge arguments, tolerance extremes, a long output hold-off and
// random arguments, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ln_taylor_series_unit_test;

  import lnts_pkg::FRAC_BITS;
  import lnts_pkg::TOL_RESET;

  localparam int SERIES_CAP = 64;
  localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [31:0] Q_TWO = 32'sh2000_0000;
  localparam logic [27:0] TOL_MAX = 28'hFFF_FFFF;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam int MAX_REPORTS = 40;

  // One result beat as the block presents it.
  typedef struct packed {
    logic signed [31:0] ln_value;
    logic [6:0]         terms_used;
    logic               limit_reached;
    logic               saturated;
  } ln_result_t;

  // A predicted result together with the argument that caused it.
  typedef struct {
    logic signed [31:0] arg;
    ln_result_t         want;
  } pending_log_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_x_value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_ln_value;
  logic [6:0] out_terms_used;
  logic out_limit_reached;
  logic out_saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [27:0] cfg_tolerance;

  pending_log_t pending_logs[$];
  logic [27:0] tolerance_now;
  int mismatch_count = 0;
  bit idle_on = 1'b1;
  int hold_len = 0;
  int hold_requests = 0;

  ln_taylor_series_unit #(
    .MAX_TERMS(SERIES_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_x_value(in_x_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ln_value(out_ln_value),
    .out_terms_used(out_terms_used),
    .out_limit_reached(out_limit_reached),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_tolerance(cfg_tolerance)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a wide value to the signed 32-bit range.
  function automatic longint clamp32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Mercator series for ln(x) with u = x - 1, in the block's fixed point.
  function automatic ln_result_t mercator_ln(input logic signed [31:0] x,
                                             input logic [27:0] tol);
    longint u;
    longint power;
    longint term;
    longint sum;
    longint wide;
    longint unsigned prod;
    longint unsigned mag;
    int count;
    int n;
    bit sat;
    bit lim;
    bit neg;
    bit done;
    ln_result_t r;
    sat = 1'b0;
    lim = 1'b0;
    done = 1'b0;
    sum = 0;
    count = 0;
    n = 1;
    u = longint'(x) - (longint'(1) << FRAC_BITS);
    if (clamp32(u) != u) sat = 1'b1;
    u = clamp32(u);
    power = u;
    term = u;
    while (!done) begin
      if (abs64(term) <= longint'(tol)) begin
        done = 1'b1;
      end else if (count >= SERIES_CAP) begin
        lim = 1'b1;
        done = 1'b1;
      end else begin
        sum += term;
        count++;
        // Next power is -(power * u), formed on magnitudes and truncated.
        prod = (abs64(power) * abs64(u)) >> FRAC_BITS;
        neg = !((power < 0) != (u < 0));
        wide = neg ? -longint'(prod) : longint'(prod);
        if (clamp32(wide) != wide) sat = 1'b1;
        power = clamp32(wide);
        n++;
        mag = abs64(power) / longint'(n);
        term = (power < 0) ? -longint'(mag) : longint'(mag);
      end
    end
    if (clamp32(sum) != sum) sat = 1'b1;
    r.ln_value = 32'(clamp32(sum));
    r.terms_used = 7'(count);
    r.limit_reached = lim;
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Arguments weighted toward the convergent region around 1.0.
  function automatic logic signed [31:0] pick_arg();
    int unsigned r;
    int off;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      off = int'($urandom_range(0, 32'h1800_0000)) - 32'sh0C00_0000;
      return Q_ONE + off;
    end
    if (r < 75) begin
      off = int'($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000;
      return Q_ONE + off;
    end
    if (r < 92) return $urandom_range(1, 32'h2000_0000);
    return $urandom;
  endfunction

  function automatic logic [27:0] pick_tolerance();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 28'($urandom_range(1, 4096));
    if (r < 75) return 28'($urandom_range(1, 32'h0010_0000));
    return 28'($urandom_range(1, 32'h0FFF_FFFF));
  endfunction

  // Offer one argument beat and record its prediction once it is taken.
  task automatic send_arg(input logic signed [31:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_logs.push_back('{arg: x, want: mercator_ln(x, tolerance_now)});
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk);
  endtask

  // Registers change only while nothing is in flight.
  task automatic set_tolerance(input logic [27:0] tol);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_tolerance <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tolerance_now = tol;
  endtask

  // Edge arguments at the reset tolerance: zero u, divergence, clipped u.
  task automatic test_directed_args();
    send_arg(Q_ONE);
    send_arg(Q_ONE + 1);
    send_arg(Q_ONE - 1);
    send_arg(32'sh1800_0000);
    send_arg(32'sh0800_0000);
    send_arg(Q_TWO);
    send_arg(32'sh0000_0000);
    send_arg(32'sh0000_0001);
    send_arg(32'sh7FFF_FFFF);
    send_arg(32'sh8000_0000);
    send_arg(32'sh9000_0000);
    send_arg(32'sh8FFF_FFFF);
    send_arg(32'shFFFF_FFFF);
  endtask

  // Zero, largest and smallest nonzero tolerance.
  task automatic test_tolerance_extremes();
    set_tolerance(28'd0);
    send_arg(Q_ONE);
    send_arg(32'sh1400_0000);
    send_arg(32'sh0C00_0000);
    send_arg(Q_TWO);
    set_tolerance(TOL_MAX);
    send_arg(32'sh0800_0000);
    send_arg(Q_TWO);
    send_arg(32'sh7FFF_FFFF);
    set_tolerance(28'd1);
    send_arg(32'sh1200_0000);
    send_arg(32'sh0E00_0000);
  endtask

  // Hold the result side off long enough that the block fills and stalls
  // its input, while capped arguments keep coming.
  task automatic test_output_holdoff();
    drain_results();
    hold_len = 8000;
    hold_requests++;
    repeat (4) send_arg(Q_TWO);
    drain_results();
  endtask

  // Random arguments over several random tolerances; one phase runs without
  // any gaps on either side.
  task automatic test_random_convergent();
    for (int phase = 0; phase < 5; phase++) begin
      set_tolerance(pick_tolerance());
      idle_on = (phase != 2);
      repeat (40) send_arg(pick_arg());
    end
    idle_on = 1'b1;
  endtask

  // Arguments spread over the whole 32-bit range, mostly divergent.
  task automatic test_random_full_range();
    set_tolerance(TOL_RESET);
    repeat (35) send_arg($urandom);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin : out_ready_driver
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = hold_len;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    pending_log_t exp_log;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      if (pending_logs.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, ln %h", out_ln_value));
      end else begin
        exp_log = pending_logs.pop_front();
        if (out_ln_value !== exp_log.want.ln_value)
          report_mismatch($sformatf("x %h: ln_value %h, expected %h", exp_log.arg,
                                    out_ln_value, exp_log.want.ln_value));
        if (out_terms_used !== exp_log.want.terms_used)
          report_mismatch($sformatf("x %h: terms_used %0d, expected %0d", exp_log.arg,
                                    out_terms_used, exp_log.want.terms_used));
        if (out_limit_reached !== exp_log.want.limit_reached)
          report_mismatch($sformatf("x %h: limit_reached %b, expected %b", exp_log.arg,
                                    out_limit_reached, exp_log.want.limit_reached));
        if (out_saturated !== exp_log.want.saturated)
          report_mismatch($sformatf("x %h: saturated %b, expected %b", exp_log.arg,
                                    out_saturated, exp_log.want.saturated));
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_value = '0;
    cfg_valid = 1'b0;
    cfg_tolerance = '0;
    tolerance_now = TOL_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_args();
    test_tolerance_extremes();
    test_output_holdoff();
    test_random_convergent();
    test_random_full_range();

    // Anything left over or arriving late shows up here.
    drain_results();
    repeat (2500) @(posedge clk);
    if (pending_logs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_logs.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout at several times the slowest correct run, where every item
  // runs to the term cap and every beat meets the longest stalls.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
